[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SPS_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("%m: check failed");

`define SPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

`define SPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define SPS_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define SPS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SPS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hw/rtl/sps_pkg.sv]
package sps_pkg;

    localparam int DATA_W = 6;
    localparam int CFG_W  = 6;
    localparam int ACT_W  = 2;

    localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(32);

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_REJECT = 2'd2
    } t_action;

    typedef struct packed {
        logic load;
        logic step;
        logic fix;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    out_free;
    } t_status;

endpackage

[hw/rtl/sps_in_if.sv]
interface sps_in_if;
    import sps_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] target;

    modport source (output valid, output target, input ready);
    modport sink   (input valid, input target, output ready);
endinterface

[hw/rtl/sps_out_if.sv]
interface sps_out_if;
    import sps_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] value;
    logic              last;

    modport source (output valid, output action, output value, output last, input ready);
    modport sink   (input valid, input action, input value, input last, output ready);
endinterface

[hw/rtl/sps_ctrl.sv]
module sps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sps_pkg::t_status i_status,
    output sps_pkg::t_cmd    o_cmd
);
    import sps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_FIX  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    unique case (i_status.action)
                        ACT_POP:    n_state = S_FIX;
                        ACT_REJECT: n_state = S_IDLE;
                        default:    n_state = S_EVAL;
                    endcase
                end
            end
            S_FIX: begin
                // refill the top of stack from memory
                o_cmd.fix = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/sps_dp.sv]
`include "assert_macros.svh"

module sps_dp #(
    parameter int MAX_LEN = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [sps_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic [sps_pkg::DATA_W-1:0] i_target,
    input  sps_pkg::t_cmd             i_cmd,
    output sps_pkg::t_status          o_status,
    sps_out_if.source                 o_out
);
    import sps_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(MAX_LEN + 2);
    localparam int IW = $clog2(MAX_LEN);

    logic [CFG_W-1:0]  r_len_cfg;
    logic [DATA_W-1:0] r_target;
    logic [LW-1:0]     r_level, n_level;
    logic [CW-1:0]     r_next, n_next;
    logic [LW-1:0]     r_seen, n_seen;
    logic              r_failed, n_failed;
    logic [DATA_W-1:0] r_top, n_top;
    logic [DATA_W-1:0] r_mem [MAX_LEN];
    logic [DATA_W-1:0] r_rdata;
    logic              r_ovalid, n_ovalid;
    t_action           r_oact, n_oact;
    logic [DATA_W-1:0] r_oval, n_oval;
    logic              r_olast, n_olast;

    logic [LW-1:0]     w_len;
    logic              w_need_push;
    logic              w_overflow;
    t_action           w_action;
    logic [IW-1:0]     w_raddr;
    logic [LW-1:0]     w_seen_inc;

    always_comb begin
        if (r_len_cfg == '0) begin
            w_len = LW'(1);
        end else if ({1'b0, r_len_cfg} > (CFG_W + 1)'(MAX_LEN)) begin
            w_len = LW'(MAX_LEN);
        end else begin
            w_len = LW'(r_len_cfg);
        end
    end

    assign w_need_push = (r_level == '0) || (r_top < r_target);
    assign w_overflow  = (r_next > CW'(w_len)) || (r_level >= LW'(MAX_LEN));
    assign w_seen_inc  = r_seen + LW'(1);
    assign w_raddr     = IW'(r_level - LW'(2));

    always_comb begin
        priority if (r_failed || r_target == '0) begin
            w_action = ACT_REJECT;
        end else if (w_need_push) begin
            w_action = w_overflow ? ACT_REJECT : ACT_PUSH;
        end else if (r_top > r_target) begin
            w_action = ACT_REJECT;
        end else begin
            w_action = ACT_POP;
        end
    end

    assign o_status.action   = w_action;
    assign o_status.out_free = !r_ovalid || o_out.ready;

    always_comb begin
        n_level  = r_level;
        n_next   = r_next;
        n_seen   = r_seen;
        n_failed = r_failed;
        n_top    = r_top;
        n_ovalid = r_ovalid && !o_out.ready;
        n_oact   = r_oact;
        n_oval   = r_oval;
        n_olast  = r_olast;
        if (i_cmd.fix) begin
            n_top = r_rdata;
        end
        if (i_cmd.step) begin
            n_ovalid = 1'b1;
            n_oact   = w_action;
            n_olast  = (w_action != ACT_PUSH);
            unique case (w_action)
                ACT_PUSH: begin
                    n_oval  = DATA_W'(r_next);
                    n_level = r_level + LW'(1);
                    n_next  = r_next + CW'(1);
                    n_top   = DATA_W'(r_next);
                end
                ACT_POP: begin
                    n_oval = r_target;
                    if (w_seen_inc >= w_len) begin
                        n_level = '0;
                        n_next  = CW'(1);
                        n_seen  = '0;
                    end else begin
                        n_level = r_level - LW'(1);
                        n_seen  = w_seen_inc;
                    end
                end
                default: begin
                    n_oval   = '0;
                    n_failed = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg <= LEN_RESET;
            r_level   <= '0;
            r_next    <= CW'(1);
            r_seen    <= '0;
            r_failed  <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_len_cfg <= i_cfg_wr_data;
            end
            r_level  <= n_level;
            r_next   <= n_next;
            r_seen   <= n_seen;
            r_failed <= n_failed;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= i_target;
        end
        r_top   <= n_top;
        r_oact  <= n_oact;
        r_oval  <= n_oval;
        r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_action == ACT_PUSH) begin
            r_mem[IW'(r_level)] <= DATA_W'(r_next);
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_out.valid  = r_ovalid;
    assign o_out.action = r_oact;
    assign o_out.value  = r_oval;
    assign o_out.last   = r_olast;

    `SPS_ASSERT_ALWAYS(a_level_bound, i_clk, i_rst_n, r_level <= LW'(MAX_LEN))
    `SPS_ASSERT_NXT(a_reject_sticks, i_clk, i_rst_n, i_cmd.step && w_action == ACT_REJECT, r_failed)
    `SPS_ASSERT_NXT(a_push_top, i_clk, i_rst_n, i_cmd.step && w_action == ACT_PUSH, r_top == $past(DATA_W'(r_next)))
    `SPS_ASSERT_IMP(a_step_free, i_clk, i_rst_n, i_cmd.step, !r_ovalid || o_out.ready)

endmodule

[hw/rtl/stack_permutation_sequencer_core.sv]
// Per target: accept (the input beat loads the target register), P pushes, a pop and a
//   top-of-stack refill from the stack memory; a reject ends the target after its pushes.
//   Results are registered from S_EVAL on; a new target is accepted only in S_IDLE.
// Output stalls hold the sequencer in place, one result register per result beat.
// Reset (i_rst_n low at a clock edge, synchronous): empty stack, next push 1,
//   no targets seen, not failed, sequence length 32.
module stack_permutation_sequencer_core #(
    parameter int MAX_LEN = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [sps_pkg::CFG_W-1:0] i_cfg_wr_data,
    sps_in_if.sink                    i_in,
    sps_out_if.source                 o_out
);
    import sps_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    sps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sps_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_target      (i_in.target),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out         (o_out)
    );

endmodule
